FILE: rtl/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg: shared types, constants and font tables of the glyph renderer
// frame store geometry, operation codes, 5x7 font rom and bit spreading
// ----------------------------------------------------------------------------
package gfr_pkg;

  localparam int DISPLAY_WIDTH = 128;
  localparam int PAGE_COUNT    = 8;
  localparam int STORE_SIZE    = PAGE_COUNT * DISPLAY_WIDTH;
  localparam int ADDR_W        = $clog2(STORE_SIZE);
  // page width holds the lower page of a doubled draw for the range check
  localparam int PG_W          = $clog2(PAGE_COUNT) + 2;
  // signed column width: x_pos plus the draw offset and the width compare
  localparam int XW            = ($clog2(DISPLAY_WIDTH) + 2 > 10) ?
                                 $clog2(DISPLAY_WIDTH) + 2 : 10;

  localparam int FIRST_CODE = 32;
  localparam int LAST_CODE  = 90;
  localparam int LOWER_A    = 97;
  localparam int LOWER_Z    = 122;
  localparam int CASE_SHIFT = 32;

  localparam int SINGLE_LAST = 5;   // 5 glyph columns and one blank
  localparam int DOUBLE_LAST = 23;  // 12 columns on two pages
  localparam int GLYPH_COLS  = 5;
  localparam int DOUBLE_COLS = 10;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef logic [0:4][7:0] glyph_row_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } col_res_t;

  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= 8'(LOWER_A) && c <= 8'(LOWER_Z)) begin
      c = c - 8'(CASE_SHIFT);
    end
    if (c < 8'(FIRST_CODE) || c > 8'(LAST_CODE)) begin
      c = 8'(FIRST_CODE);
    end
    return 6'(c - 8'(FIRST_CODE));
  endfunction

  function automatic glyph_row_t glyph_row(input logic [5:0] g);
    glyph_row_t r;
    case (g)
      6'd0:  r = 40'h0000000000;
      6'd1:  r = 40'h00005F0000;
      6'd2:  r = 40'h0007000700;
      6'd3:  r = 40'h147F147F14;
      6'd4:  r = 40'h242A7F2A12;
      6'd5:  r = 40'h2313086462;
      6'd6:  r = 40'h3649552250;
      6'd7:  r = 40'h0005030000;
      6'd8:  r = 40'h001C224100;
      6'd9:  r = 40'h0041221C00;
      6'd10: r = 40'h14083E0814;
      6'd11: r = 40'h08083E0808;
      6'd12: r = 40'h0050300000;
      6'd13: r = 40'h0808080808;
      6'd14: r = 40'h0060600000;
      6'd15: r = 40'h2010080402;
      6'd16: r = 40'h3E5149453E;
      6'd17: r = 40'h00427F4000;
      6'd18: r = 40'h4261514946;
      6'd19: r = 40'h2141454B31;
      6'd20: r = 40'h1814127F10;
      6'd21: r = 40'h2745454539;
      6'd22: r = 40'h3C4A494930;
      6'd23: r = 40'h0171090503;
      6'd24: r = 40'h3649494936;
      6'd25: r = 40'h064949291E;
      6'd26: r = 40'h0036360000;
      6'd27: r = 40'h0056360000;
      6'd28: r = 40'h0814224100;
      6'd29: r = 40'h1414141414;
      6'd30: r = 40'h0041221408;
      6'd31: r = 40'h0201510906;
      6'd32: r = 40'h324979413E;
      6'd33: r = 40'h7E1111117E;
      6'd34: r = 40'h7F49494936;
      6'd35: r = 40'h3E41414122;
      6'd36: r = 40'h7F4141221C;
      6'd37: r = 40'h7F49494941;
      6'd38: r = 40'h7F09090901;
      6'd39: r = 40'h3E4149497A;
      6'd40: r = 40'h7F0808087F;
      6'd41: r = 40'h00417F4100;
      6'd42: r = 40'h2040413F01;
      6'd43: r = 40'h7F08142241;
      6'd44: r = 40'h7F40404040;
      6'd45: r = 40'h7F020C027F;
      6'd46: r = 40'h7F0408107F;
      6'd47: r = 40'h3E4141413E;
      6'd48: r = 40'h7F09090906;
      6'd49: r = 40'h3E4151215E;
      6'd50: r = 40'h7F09192946;
      6'd51: r = 40'h4649494931;
      6'd52: r = 40'h01017F0101;
      6'd53: r = 40'h3F4040403F;
      6'd54: r = 40'h1F2040201F;
      6'd55: r = 40'h3F4038403F;
      6'd56: r = 40'h6314081463;
      6'd57: r = 40'h0708700807;
      6'd58: r = 40'h6151494543;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] spread_bits(input logic [7:0] b);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[2*i +: 2] = {2{b[i]}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/glyph_framebuffer_renderer_core.sv
// ----------------------------------------------------------------------------
// glyph_framebuffer_renderer_core: 5x7 text renderer on a paged frame store
// ----------------------------------------------------------------------------
// one operation beat enters on the s_axis side (clear, draw character,
// horizontal line, read byte) and exactly one result beat leaves on the
// m_axis side carrying the read byte and the reject status.
// one shared column address unit under a small sequencer feeds a frame store
// ram with one write and one registered read per cycle; sequencer steps:
//   single draw      5 glyph columns and a blank
//   double draw      12 columns on two pages, none when rejected
//   horizontal line  every column, through the read-modify-write pipeline
//   read byte        address, then registered data
//   clear            all STORE_SIZE (1024) bytes, one byte per cycle
// the result beat is registered in the output register on leaving the done
// state, and the sequencer then returns to idle to take the next beat.
// s_axis_tready_o is high only while the sequencer is idle; a new beat is
// taken while the previous result still waits in the output register.
// after reset the store is swept to zero with tready low.
// when the receiver stalls, a finished result waits inside until the
// output register frees up, and the next beat is not taken meanwhile.
// ----------------------------------------------------------------------------
module glyph_framebuffer_renderer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] double_size, [8:1] x_pos, [11:9] page_row, [19:12] char_code,
  // [22:20] line_bit, [29:23] read_column, [31:30] zero
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] read_data, [8] status, [15:9] zero
  output logic [15:0] m_axis_tdata_o
);

  localparam int AW  = gfr_pkg::ADDR_W;
  localparam int PGW = gfr_pkg::PG_W;
  localparam int CW  = gfr_pkg::XW;

  // sequencer states
  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_DRAW      = 3'd2;
  localparam logic [2:0] ST_LINE      = 3'd3;
  localparam logic [2:0] ST_LINE_END  = 3'd4;
  localparam logic [2:0] ST_READ      = 3'd5;
  localparam logic [2:0] ST_READ_WAIT = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  logic [2:0] state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic res_pend_q, res_pend_d;

  // captured operation fields
  logic [1:0]        op_q;
  logic              dbl_q;
  logic signed [7:0] x_q;
  logic [2:0]        page_q;
  logic [5:0]        glyph_q;
  logic [2:0]        bit_q;
  logic [6:0]        rcol_q;

  logic [7:0] res_data_q, res_data_d;
  logic       res_status_q, res_status_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q;
  logic        out_status_q;
  logic        out_load;

  // line read-modify-write pipeline and read flag
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic          rd_ok_q;

  logic                 accept;
  logic [PGW-1:0]       page_ext;
  logic                 dbl_reject;
  logic [PGW-1:0]       cu_page;
  logic signed [CW-1:0] cu_col;
  gfr_pkg::col_res_t    cu_res;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // draw step decode
  logic [4:0]          step;
  logic [3:0]          col_off;
  logic [3:0]          glyph_col;
  logic                lower_page;
  logic                blank_col;
  gfr_pkg::glyph_row_t glyph_cols;
  logic [7:0]          glyph_byte;
  logic [15:0]         spread;
  logic [7:0]          draw_byte;
  logic                draw_last;
  logic [7:0]          line_mask;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign page_ext   = PGW'(page_q);
  assign dbl_reject = (PGW'(s_axis_tdata_i[11:9]) + PGW'(1)) >=
                      PGW'(gfr_pkg::PAGE_COUNT);

  assign step       = cnt_q[4:0];
  assign col_off    = dbl_q ? step[4:1] : step[3:0];
  assign lower_page = dbl_q && step[0];
  assign glyph_col  = dbl_q ? {1'b0, col_off[3:1]} : col_off;
  assign blank_col  = dbl_q ? (col_off >= 4'(gfr_pkg::DOUBLE_COLS)) :
                              (col_off >= 4'(gfr_pkg::GLYPH_COLS));
  assign glyph_cols = gfr_pkg::glyph_row(glyph_q);
  assign glyph_byte = blank_col ? 8'h00 : glyph_cols[glyph_col[2:0]];
  assign spread     = gfr_pkg::spread_bits(glyph_byte);
  assign draw_byte  = !dbl_q ? glyph_byte :
                      (lower_page ? spread[15:8] : spread[7:0]);
  assign draw_last  = dbl_q ? (step == 5'(gfr_pkg::DOUBLE_LAST)) :
                              (step == 5'(gfr_pkg::SINGLE_LAST));
  assign line_mask  = 8'h01 << bit_q;

  gfr_col_unit u_col (
    .page_i (cu_page),
    .col_i  (cu_col),
    .res_o  (cu_res)
  );

  gfr_ram #(
    .WIDTH (8),
    .DEPTH (gfr_pkg::STORE_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer and shared unit steering
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    res_pend_d   = res_pend_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    cu_page      = page_ext;
    cu_col       = CW'(x_q);
    ram_we       = 1'b0;
    ram_waddr    = cu_res.addr;
    ram_wdata    = 8'h00;
    ram_raddr    = cu_res.addr;
    out_load     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(gfr_pkg::STORE_SIZE - 1)) begin
          cnt_d   = '0;
          state_d = res_pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_pend_d   = 1'b1;
          res_data_d   = 8'h00;
          res_status_d = 1'b0;
          cnt_d        = '0;
          case (s_axis_tuser_i)
            gfr_pkg::OP_CLEAR: state_d = ST_CLEAR;
            gfr_pkg::OP_DRAW: begin
              if (s_axis_tdata_i[0] && dbl_reject) begin
                res_status_d = 1'b1;
                state_d      = ST_DONE;
              end else begin
                state_d = ST_DRAW;
              end
            end
            gfr_pkg::OP_LINE: state_d = ST_LINE;
            gfr_pkg::OP_READ: state_d = ST_READ;
            default:          state_d = ST_DONE;
          endcase
        end
      end
      ST_DRAW: begin
        cu_page   = page_ext + PGW'(lower_page);
        cu_col    = CW'(x_q) + $signed(CW'(col_off));
        ram_we    = cu_res.ok;
        ram_wdata = draw_byte;
        cnt_d     = cnt_q + AW'(1);
        if (draw_last) begin
          state_d = ST_DONE;
        end
      end
      ST_LINE: begin
        // read column cnt while the previous column is written back
        cu_col    = $signed(CW'(cnt_q));
        ram_we    = wr_pend_q;
        ram_waddr = wr_addr_q;
        ram_wdata = ram_rdata | line_mask;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(gfr_pkg::DISPLAY_WIDTH - 1)) begin
          state_d = ST_LINE_END;
        end
      end
      ST_LINE_END: begin
        ram_we    = wr_pend_q;
        ram_waddr = wr_addr_q;
        ram_wdata = ram_rdata | line_mask;
        state_d   = ST_DONE;
      end
      ST_READ: begin
        cu_col  = $signed(CW'(rcol_q));
        state_d = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        res_data_d = rd_ok_q ? ram_rdata : 8'h00;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_q || m_axis_tready_i) begin
          out_load   = 1'b1;
          res_pend_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wr_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_pend_q  <= res_pend_d;
      out_valid_q <= out_valid_d;
      wr_pend_q   <= (state_q == ST_LINE) && cu_res.ok;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser_i;
      dbl_q   <= s_axis_tdata_i[0];
      x_q     <= $signed(s_axis_tdata_i[8:1]);
      page_q  <= s_axis_tdata_i[11:9];
      glyph_q <= gfr_pkg::glyph_index(s_axis_tdata_i[19:12]);
      bit_q   <= s_axis_tdata_i[22:20];
      rcol_q  <= s_axis_tdata_i[29:23];
    end
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    wr_addr_q    <= cu_res.addr;
    rd_ok_q      <= cu_res.ok && (op_q == gfr_pkg::OP_READ);
    if (out_load) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_status_q, out_data_q};

endmodule

FILE: rtl/gfr_ram.sv
// ----------------------------------------------------------------------------
// gfr_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module gfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gfr_col_unit.sv
// ----------------------------------------------------------------------------
// gfr_col_unit: shared column address unit
// clips a page and signed column to the store and forms the byte address
// ----------------------------------------------------------------------------
module gfr_col_unit (
  input  logic                         [gfr_pkg::PG_W-1:0] page_i,
  input  logic signed                  [gfr_pkg::XW-1:0]   col_i,
  output gfr_pkg::col_res_t                                res_o
);

  logic page_ok;
  logic col_ok;

  assign page_ok = page_i < gfr_pkg::PG_W'(gfr_pkg::PAGE_COUNT);
  // sign bit clear first, then an unsigned compare against the width
  assign col_ok  = !col_i[gfr_pkg::XW-1] &&
                   ($unsigned(col_i) < gfr_pkg::XW'(gfr_pkg::DISPLAY_WIDTH));

  assign res_o.ok   = page_ok && col_ok;
  assign res_o.addr = gfr_pkg::ADDR_W'(page_i) *
                      gfr_pkg::ADDR_W'(gfr_pkg::DISPLAY_WIDTH) +
                      gfr_pkg::ADDR_W'($unsigned(col_i));

endmodule

FILE: tb/sv/glyph_render_monitor.sv
// ----------------------------------------------------------------------------
// glyph_render_monitor: result predictor and comparator for the glyph renderer
// keeps its own copy of the paged frame store, works out the read byte and
// reject status of every operation beat, and compares result beats in order
// ----------------------------------------------------------------------------
module glyph_render_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_valid_i,
  input  logic        op_ready_i,
  // [0] double_size, [8:1] x_pos, [11:9] page_row, [19:12] char_code,
  // [22:20] line_bit, [29:23] read_column, [31:30] zero
  input  logic [31:0] op_data_i,
  // [1:0] operation
  input  logic [1:0]  op_kind_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  // [7:0] read_data, [8] status, [15:9] zero
  input  logic [15:0] res_data_i,
  output int          mismatch_count_o,
  output int          replies_owed_o
);

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } reply_t;

  // 5x7 font, code 32 first; each word holds columns 0..4 from the top byte down
  localparam logic [0:58][39:0] FONT_COLS = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543
  };

  logic [7:0] pixels [gfr_pkg::PAGE_COUNT][gfr_pkg::DISPLAY_WIDTH];
  reply_t     owed_replies [$];
  int         mismatches;

  function automatic void wipe_pixels();
    for (int p = 0; p < gfr_pkg::PAGE_COUNT; p++) begin
      for (int c = 0; c < gfr_pkg::DISPLAY_WIDTH; c++) begin
        pixels[p][c] = 8'h00;
      end
    end
  endfunction

  // lowercase folds to uppercase, anything outside the font draws as space
  function automatic int font_slot(logic [7:0] code);
    int c;
    c = int'(code);
    if (c >= 97 && c <= 122) begin
      c = c - 32;
    end
    if (c < 32 || c > 90) begin
      c = 32;
    end
    return c - 32;
  endfunction

  function automatic logic [7:0] font_column(int slot, int col);
    logic [39:0] word;
    word = FONT_COLS[slot];
    return word[39-8*col -: 8];
  endfunction

  // every glyph bit becomes two vertical pixels
  function automatic logic [15:0] stretch_bits(logic [7:0] b);
    logic [15:0] s;
    for (int i = 0; i < 8; i++) begin
      s[2*i]   = b[i];
      s[2*i+1] = b[i];
    end
    return s;
  endfunction

  // writes outside the store are dropped
  function automatic void put_pixels(int page, int col, logic [7:0] v);
    if (page >= 0 && page < gfr_pkg::PAGE_COUNT &&
        col >= 0 && col < gfr_pkg::DISPLAY_WIDTH) begin
      pixels[page][col] = v;
    end
  endfunction

  function automatic reply_t render_op(logic [1:0] kind, logic [31:0] d);
    reply_t      r;
    int          x;
    int          page;
    int          slot;
    int          rcol;
    logic [15:0] tall;
    r    = '0;
    x    = $signed(d[8:1]);
    page = int'(d[11:9]);
    rcol = int'(d[29:23]);
    case (kind)
      gfr_pkg::OP_CLEAR: begin
        wipe_pixels();
      end
      gfr_pkg::OP_DRAW: begin
        slot = font_slot(d[19:12]);
        if (!d[0]) begin
          if (page < gfr_pkg::PAGE_COUNT) begin
            for (int i = 0; i < 5; i++) begin
              put_pixels(page, x + i, font_column(slot, i));
            end
            put_pixels(page, x + 5, 8'h00);
          end
        end else if (page + 1 >= gfr_pkg::PAGE_COUNT) begin
          r.status = 1'b1;
        end else begin
          for (int i = 0; i < 5; i++) begin
            tall = stretch_bits(font_column(slot, i));
            put_pixels(page,     x + 2*i,     tall[7:0]);
            put_pixels(page + 1, x + 2*i,     tall[15:8]);
            put_pixels(page,     x + 2*i + 1, tall[7:0]);
            put_pixels(page + 1, x + 2*i + 1, tall[15:8]);
          end
          for (int i = 10; i < 12; i++) begin
            put_pixels(page,     x + i, 8'h00);
            put_pixels(page + 1, x + i, 8'h00);
          end
        end
      end
      gfr_pkg::OP_LINE: begin
        if (page < gfr_pkg::PAGE_COUNT) begin
          for (int c = 0; c < gfr_pkg::DISPLAY_WIDTH; c++) begin
            pixels[page][c] = pixels[page][c] | (8'h01 << d[22:20]);
          end
        end
      end
      default: begin
        if (page < gfr_pkg::PAGE_COUNT && rcol < gfr_pkg::DISPLAY_WIDTH) begin
          r.read_data = pixels[page][rcol];
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      wipe_pixels();
      owed_replies.delete();
      mismatches = 0;
    end else begin
      // compare before queueing, a beat taken this edge cannot be answered yet
      if (res_valid_i && res_ready_i) begin
        if (owed_replies.size() == 0) begin
          $error("result beat with no operation waiting: data %h", res_data_i);
          mismatches++;
        end else begin
          want = owed_replies.pop_front();
          if (res_data_i[7:0] !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, res_data_i[7:0]);
            mismatches++;
          end
          if (res_data_i[8] !== want.status) begin
            $error("status: expected %b, got %b", want.status, res_data_i[8]);
            mismatches++;
          end
        end
      end
      if (op_valid_i && op_ready_i) begin
        owed_replies.push_back(render_op(op_kind_i, op_data_i));
      end
    end
    mismatch_count_o <= mismatches;
    replies_owed_o   <= owed_replies.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level test of the glyph frame store renderer
// drives clear, draw, line and read beats with random gaps and output stalls,
// a monitor predicts each result; a watchdog ends a run that stops moving
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_OPS  = 1700;
  localparam int STALL_LIMIT = 10000;  // outlasts a clear or the reset sweep
  localparam int DRAIN_WAIT  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  int render_fails;
  int replies_owed;
  int quiet_cycles;
  bit steady_flow;
  int recv_hold;
  int last_page;
  int last_x;

  glyph_framebuffer_renderer_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  glyph_render_monitor i_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_valid_i       (s_tvalid),
    .op_ready_i       (s_tready),
    .op_data_i        (s_tdata),
    .op_kind_i        (s_tuser),
    .res_valid_i      (m_tvalid),
    .res_ready_i      (m_tready),
    .res_data_i       (m_tdata),
    .mismatch_count_o (render_fails),
    .replies_owed_o   (replies_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, changed at the falling edge
  initial begin
    m_tready  = 1'b0;
    recv_hold = 0;
    forever begin
      @(negedge clk_i);
      if (recv_hold > 0) begin
        m_tready  = 1'b0;
        recv_hold--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          recv_hold = pick_gap();
        end
      end
    end
  end

  // watchdog: cycles in which neither side moves a beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one operation beat; valid stays high into the next beat when there is no gap
  task automatic send_op(input logic [1:0] kind, input logic dbl, input logic [7:0] x,
                         input logic [2:0] page, input logic [7:0] code,
                         input logic [2:0] lbit, input logic [6:0] rcol);
    int idle;
    idle = pick_gap();
    @(negedge clk_i);
    if (idle > 0) begin
      s_tvalid = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {2'b00, rcol, lbit, code, page, x, dbl};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_random_op();
    logic [1:0] kind;
    logic       dbl;
    logic [7:0] x;
    logic [2:0] page;
    logic [7:0] code;
    logic [2:0] lbit;
    logic [6:0] rcol;
    int         r;
    int         xi;
    // unused fields carry random content too
    dbl  = 1'($urandom);
    x    = 8'($urandom);
    page = 3'($urandom);
    code = 8'($urandom);
    lbit = 3'($urandom);
    rcol = 7'($urandom);
    r    = $urandom_range(0, 99);
    if (r < 2) begin
      kind = gfr_pkg::OP_CLEAR;
    end else if (r < 8) begin
      kind = gfr_pkg::OP_LINE;
    end else if (r < 58) begin
      kind = gfr_pkg::OP_DRAW;
      dbl  = ($urandom_range(0, 99) < 40);
      if ($urandom_range(0, 99) < 85) begin
        // mostly on screen, with partial clipping on both edges
        xi = int'($urandom_range(0, 139)) - 12;
        x  = xi[7:0];
      end
      r = $urandom_range(0, 3);
      if (r < 2) begin
        code = 8'($urandom_range(32, 90));
      end else if (r == 2) begin
        code = 8'($urandom_range(97, 122));
      end
      last_page = int'(page);
      last_x    = $signed(x);
    end else begin
      kind = gfr_pkg::OP_READ;
      // half of the reads look at the area of the latest draw
      if ($urandom_range(0, 1) == 0) begin
        page = 3'(last_page + $urandom_range(0, 1));
        xi   = last_x + int'($urandom_range(0, 13));
        if (xi >= 0 && xi < gfr_pkg::DISPLAY_WIDTH) begin
          rcol = xi[6:0];
        end
      end
    end
    send_op(kind, dbl, x, page, code, lbit, rcol);
  endtask

  initial begin
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = gfr_pkg::OP_CLEAR;
    steady_flow = 1'b0;
    last_page   = 0;
    last_x      = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty store, glyph columns, case folding, codes outside the font,
    // clipping on both edges, doubled draws and the bottom-page reject
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd0, 8'd0,   3'd0, 7'd0);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd7, 8'd0,   3'd0, 7'd127);
    send_op(gfr_pkg::OP_DRAW,  1'b0, 8'd0,   3'd0, 8'd65,  3'd0, 7'd0);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd0, 8'd0,   3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b1, 8'hFD,  3'd6, 8'd97,  3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b1, 8'd20,  3'd7, 8'd122, 3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b0, 8'd120, 3'd3, 8'd200, 3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b0, 8'd125, 3'd3, 8'd31,  3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b0, 8'h80,  3'd2, 8'd91,  3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b1, 8'd127, 3'd0, 8'd90,  3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b1, 8'hF5,  3'd5, 8'd32,  3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b0, 8'hFC,  3'd4, 8'd33,  3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b0, 8'd122, 3'd7, 8'd48,  3'd0, 7'd0);
    send_op(gfr_pkg::OP_DRAW,  1'b1, 8'd100, 3'd1, 8'd255, 3'd0, 7'd0);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd6, 8'd0,   3'd0, 7'd0);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd7, 8'd0,   3'd0, 7'd1);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd4, 8'd0,   3'd0, 7'd0);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd7, 8'd0,   3'd0, 7'd127);
    send_op(gfr_pkg::OP_LINE,  1'b0, 8'd0,   3'd0, 8'd0,   3'd0, 7'd0);
    send_op(gfr_pkg::OP_LINE,  1'b0, 8'd0,   3'd7, 8'd0,   3'd7, 7'd0);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd0, 8'd0,   3'd0, 7'd127);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd7, 8'd0,   3'd0, 7'd0);
    send_op(gfr_pkg::OP_CLEAR, 1'b0, 8'd0,   3'd0, 8'd0,   3'd0, 7'd0);
    send_op(gfr_pkg::OP_READ,  1'b0, 8'd0,   3'd7, 8'd0,   3'd0, 7'd127);

    // random operations, with runs in which neither side idles
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if ($urandom_range(0, 149) == 0) begin
        steady_flow = !steady_flow;
      end
      send_random_op();
    end
    @(negedge clk_i);
    s_tvalid = 1'b0;

    wait (replies_owed == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (render_fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gfr_pkg.sv
rtl/gfr_ram.sv
rtl/gfr_col_unit.sv
rtl/glyph_framebuffer_renderer_core.sv
tb/sv/glyph_render_monitor.sv
tb/sv/testbench.sv
